// ===== hdl/dmg_pkg.sv =====
// Shared types and constants of the maze carving core.
package dmg_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_MOVE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CARVED   = 2'd0,
    ST_BACK     = 2'd1,
    ST_FINISHED = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_WALL = 2'd0,
    CELL_PATH = 2'd1,
    CELL_SEEN = 2'd2
  } cell_e;

  typedef enum logic [1:0] {
    MV_UP    = 2'd0,
    MV_DOWN  = 2'd1,
    MV_LEFT  = 2'd2,
    MV_RIGHT = 2'd3
  } move_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_CLR_FIX,
    S_MARK,
    S_PROBE,
    S_PROBE_WAIT,
    S_CHECK,
    S_POP,
    S_POP_WAIT,
    S_RD_WAIT,
    S_MV_WAIT,
    S_DONE
  } state_e;

  localparam int unsigned REG_WIDTH  = 0;
  localparam int unsigned REG_HEIGHT = 1;
  localparam logic [5:0] RESET_WIDTH  = 6'd41;
  localparam logic [5:0] RESET_HEIGHT = 6'd25;

  // Direction codes in the shuffle: 0 row+1, 1 row-1, 2 col+1, 3 col-1.
  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

endpackage

// ===== hdl/dfs_maze_generator_core.sv =====
// Top level of the maze carving core: sequencer, grid memory and return stack.
//
//  channel | signals                                         | direction
//  command | start_i, busy_o, command_i, pick_*_i, cell_*_i, | in (busy_o out)
//          | direction_i                                     |
//  result  | done_o, status_o, walker_*_o, cell_value_o,     | out
//          | player_*_o, reached_exit_o                      |
//  config  | cfg_we_i, cfg_index_i, cfg_data_i               | in
//
// A read passes through S_RD_WAIT and S_DONE, a move first through S_MV_WAIT.
// A step probes neighbors one at a time on the one grid port (S_PROBE, S_PROBE_WAIT,
// S_CHECK). A clear sweeps all grid memory entries, one a cycle, then runs S_CLR_FIX.
// After reset the same sweep runs, with busy_o high and no result, to lay out the grid.
// The result is shown for one cycle on done_o; the receiver cannot stall.
module dfs_maze_generator_core #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64,
  parameter int STACK_DEPTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] command_i,
  input  logic [1:0] pick_0_i,
  input  logic [1:0] pick_1_i,
  input  logic [1:0] pick_2_i,
  input  logic [1:0] pick_3_i,
  input  logic [5:0] cell_column_i,
  input  logic [5:0] cell_row_i,
  input  logic [1:0] direction_i,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [5:0] cfg_data_i,
  output logic       done_o,
  output logic [1:0] status_o,
  output logic [5:0] walker_column_o,
  output logic [5:0] walker_row_o,
  output logic [1:0] cell_value_o,
  output logic [5:0] player_column_o,
  output logic [5:0] player_row_o,
  output logic       reached_exit_o
);
  import dmg_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = CW + RW;
  localparam int DEPTH = 1 << AW;
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int PW = 8;  // signed coordinate width, covers -2..65

  logic [1:0] grid_mem [DEPTH];
  logic [11:0] stack_mem [STACK_DEPTH];

  state_e state_q, state_d;
  logic [5:0] width_q, height_q;
  logic [SW:0] sp_q, sp_d;
  logic [5:0] wc_q, wc_d, wr_q, wr_d, pc_q, pc_d, pr_q, pr_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic [1:0] ord_q [4];
  logic [1:0] ord_d [4];
  logic [1:0] idx_q, idx_d;
  logic [1:0] cmd_q, dir_q;
  logic [1:0] status_q, status_d, value_q, value_d;
  logic done_q, done_d;
  logic boot_q;

  // used size, clipped to the memory
  logic [8:0] uc, ur;
  assign uc = ({3'd0, width_q} > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : {3'd0, width_q};
  assign ur = ({3'd0, height_q} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {3'd0, height_q};

  function automatic logic in_grid(input logic signed [PW-1:0] c, input logic signed [PW-1:0] r,
                                   input logic [8:0] w, input logic [8:0] h);
    in_grid = (c >= 0) && (r >= 0) && ({1'b0, c} < 9'(w)) && ({1'b0, r} < 9'(h));
  endfunction

  // single grid port request
  logic g_we, g_re, g_all;
  logic signed [PW-1:0] g_c, g_r;
  logic [1:0] g_wd, g_rd_q;
  logic g_in, g_in_q;
  logic [AW-1:0] g_addr;
  assign g_in = in_grid(g_c, g_r, uc, ur);
  assign g_addr = {g_r[RW-1:0], g_c[CW-1:0]};

  always_ff @(posedge clk_i) begin
    if (g_we && (g_in || g_all)) grid_mem[g_addr] <= g_wd;
    if (g_re) g_rd_q <= grid_mem[g_addr];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_in_q <= 1'b0;
    else if (g_re) g_in_q <= g_in;
  end
  logic [1:0] g_val;
  assign g_val = g_in_q ? g_rd_q : CELL_WALL;

  // stack port
  logic s_we, s_re;
  logic [SW-1:0] s_addr;
  logic [11:0] s_rd_q;
  always_ff @(posedge clk_i) begin
    if (s_we) stack_mem[s_addr] <= {wr_q, wc_q};
    if (s_re) s_rd_q <= stack_mem[s_addr];
  end

  // probe geometry for the current direction
  logic [1:0] dcur;
  logic signed [PW-1:0] dx, dy, nx, ny;
  assign dcur = ord_q[idx_q];
  always_comb begin
    dx = '0; dy = '0;
    case (dcur)
      DIR_DOWN:  dy = 8'sd1;
      DIR_UP:    dy = -8'sd1;
      DIR_RIGHT: dx = 8'sd1;
      default:   dx = -8'sd1;
    endcase
    nx = $signed({2'b0, wc_q}) + (dx <<< 1);
    ny = $signed({2'b0, wr_q}) + (dy <<< 1);
  end
  logic nb_ok;
  assign nb_ok = (nx > 0) && (ny > 0) && ({1'b0, nx} < 9'(uc)) && ({1'b0, ny} < 9'(ur));

  logic signed [PW-1:0] mc, mr;
  always_comb begin
    mc = $signed({2'b0, pc_q}); mr = $signed({2'b0, pr_q});
    case (dir_q)
      MV_UP:   mr = mr - 8'sd1;
      MV_DOWN: mr = mr + 8'sd1;
      MV_LEFT: mc = mc - 8'sd1;
      default: mc = mc + 8'sd1;
    endcase
  end

  logic [CW-1:0] sw_c;
  logic [RW-1:0] sw_r;
  assign sw_c = sweep_q[CW-1:0];
  assign sw_r = sweep_q[AW-1:CW];

  always_comb begin
    logic [1:0] t;
    state_d = state_q; sp_d = sp_q; wc_d = wc_q; wr_d = wr_q; pc_d = pc_q; pr_d = pr_q;
    sweep_d = sweep_q; ord_d = ord_q; idx_d = idx_q; status_d = status_q;
    value_d = value_q; done_d = 1'b0;
    g_we = 1'b0; g_re = 1'b0; g_all = 1'b0; g_c = '0; g_r = '0; g_wd = CELL_WALL;
    s_we = 1'b0; s_re = 1'b0; s_addr = sp_q[SW-1:0];
    t = '0;
    case (state_q)
      S_IDLE: ;
      S_CLR: begin
        // raw memory sweep: lattice inside the used size, wall elsewhere
        g_c = $signed({{(PW-CW){1'b0}}, sw_c});
        g_r = $signed({{(PW-RW){1'b0}}, sw_r});
        g_we = 1'b1;
        g_all = 1'b1;
        g_wd = (in_grid(g_c, g_r, uc, ur) && sw_c[0] && sw_r[0]) ? CELL_PATH : CELL_WALL;
        if (sweep_q == AW'(DEPTH - 1)) begin
          sweep_d = '0;
          state_d = S_CLR_FIX;
        end else sweep_d = sweep_q + 1'b1;
      end
      S_CLR_FIX: begin
        if (idx_q == 2'd0) begin
          g_c = 8'sd1; g_r = 8'sd1; g_we = 1'b1; g_wd = CELL_SEEN;
          idx_d = 2'd1;
        end else begin
          g_c = $signed(PW'(uc)) - 8'sd2; g_r = $signed(PW'(ur)) - 8'sd1;
          g_we = (uc >= 9'd2) && (ur >= 9'd1); g_wd = CELL_PATH;
          idx_d = 2'd0;
          sp_d = '0; wc_d = 6'd1; wr_d = 6'd1; pc_d = 6'd1; pr_d = 6'd1;
          // The layout after reset has no command behind it, so it shows no result.
          state_d = boot_q ? S_IDLE : S_DONE;
        end
      end
      S_MARK: begin
        g_c = $signed({2'b0, wc_q}); g_r = $signed({2'b0, wr_q});
        g_we = 1'b1; g_wd = CELL_SEEN;
        idx_d = 2'd0;
        state_d = (sp_q < (SW+1)'(STACK_DEPTH)) ? S_PROBE : S_POP;
      end
      S_PROBE: begin
        if (nb_ok) begin
          g_c = nx; g_r = ny; g_re = 1'b1;
          state_d = S_PROBE_WAIT;
        end else if (idx_q == 2'd3) state_d = S_POP;
        else idx_d = idx_q + 1'b1;
      end
      S_PROBE_WAIT: state_d = S_CHECK;
      S_CHECK: begin
        if (g_val == CELL_PATH) begin
          g_c = $signed({2'b0, wc_q}) + dx; g_r = $signed({2'b0, wr_q}) + dy;
          g_we = 1'b1; g_wd = CELL_SEEN;
          s_we = 1'b1;
          sp_d = sp_q + 1'b1;
          wc_d = nx[5:0]; wr_d = ny[5:0];
          status_d = ST_CARVED;
          state_d = S_DONE;
        end else if (idx_q == 2'd3) state_d = S_POP;
        else begin
          idx_d = idx_q + 1'b1;
          state_d = S_PROBE;
        end
      end
      S_POP: begin
        if (sp_q != '0) begin
          s_addr = SW'(sp_q - 1'b1);
          s_re = 1'b1;
          sp_d = sp_q - 1'b1;
          state_d = S_POP_WAIT;
        end else begin
          status_d = ST_FINISHED;
          state_d = S_DONE;
        end
      end
      S_POP_WAIT: begin
        wc_d = s_rd_q[5:0]; wr_d = s_rd_q[11:6];
        status_d = ST_BACK;
        state_d = S_DONE;
      end
      S_RD_WAIT: begin
        value_d = g_val;
        state_d = S_DONE;
      end
      S_MV_WAIT: begin
        // The move probe reads in the cycle after the transfer, once dir_q is held.
        g_c = mc; g_r = mr; g_re = 1'b1;
        state_d = S_RD_WAIT;
      end
      S_DONE: begin
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (state_q == S_IDLE && start_i) begin
      status_d = ST_NONE; value_d = CELL_WALL;
      case (cmd_e'(command_i))
        CMD_CLEAR: begin
          sweep_d = '0; idx_d = 2'd0; state_d = S_CLR;
        end
        CMD_STEP: begin
          ord_d[0] = DIR_DOWN; ord_d[1] = DIR_UP; ord_d[2] = DIR_RIGHT; ord_d[3] = DIR_LEFT;
          t = ord_d[0]; ord_d[0] = ord_d[pick_0_i]; ord_d[pick_0_i] = t;
          t = ord_d[1]; ord_d[1] = ord_d[pick_1_i]; ord_d[pick_1_i] = t;
          t = ord_d[2]; ord_d[2] = ord_d[pick_2_i]; ord_d[pick_2_i] = t;
          t = ord_d[3]; ord_d[3] = ord_d[pick_3_i]; ord_d[pick_3_i] = t;
          state_d = S_MARK;
        end
        CMD_READ: begin
          g_c = $signed({2'b0, cell_column_i}); g_r = $signed({2'b0, cell_row_i});
          g_re = 1'b1;
          state_d = S_RD_WAIT;
        end
        default: begin
          state_d = S_MV_WAIT;
        end
      endcase
    end
    if (state_q == S_RD_WAIT && cmd_q == CMD_MOVE) begin
      value_d = CELL_WALL;
      if (g_val != CELL_WALL) begin
        pc_d = mc[5:0]; pr_d = mr[5:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      boot_q <= 1'b1;
      width_q <= RESET_WIDTH; height_q <= RESET_HEIGHT;
      sp_q <= '0; wc_q <= 6'd1; wr_q <= 6'd1; pc_q <= 6'd1; pr_q <= 6'd1;
      sweep_q <= '0; idx_q <= '0; done_q <= 1'b0;
      status_q <= ST_NONE; value_q <= CELL_WALL;
      cmd_q <= CMD_CLEAR; dir_q <= MV_UP;
      for (int i = 0; i < 4; i++) ord_q[i] <= 2'(i);
    end else begin
      state_q <= state_d; sp_q <= sp_d;
      wc_q <= wc_d; wr_q <= wr_d; pc_q <= pc_d; pr_q <= pr_d;
      sweep_q <= sweep_d; idx_q <= idx_d; done_q <= done_d;
      status_q <= status_d; value_q <= value_d; ord_q <= ord_d;
      if (state_q == S_CLR_FIX && idx_q != 2'd0) boot_q <= 1'b0;
      if (state_q == S_IDLE && start_i) begin
        cmd_q <= command_i; dir_q <= direction_i;
      end
      if (cfg_we_i && cfg_index_i == 1'(REG_WIDTH)) width_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == 1'(REG_HEIGHT)) height_q <= cfg_data_i;
    end
  end

  logic at_exit;
  assign at_exit = (uc >= 9'd2) && ({3'd0, pc_q} == uc - 9'd2) && ({3'd0, pr_q} == ur - 9'd1);

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign status_o = status_q;
  assign walker_column_o = wc_q;
  assign walker_row_o = wr_q;
  assign cell_value_o = value_q;
  assign player_column_o = pc_q;
  assign player_row_o = pr_q;
  assign reached_exit_o = done_q & at_exit;

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= (SW+1)'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result shown while busy");
  a_carve_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_CARVED) |-> sp_q == $past(sp_q, 2) + 1'b1)
    else $error("carve without push");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("transfer not taken");

endmodule

// ===== tb/sv/tb_dfs_maze_generator_core.sv =====
// Self-checking testbench for the maze carving core with a built-in maze predictor.
`timescale 1ns / 1ps

module tb_dfs_maze_generator_core;
  import dmg_pkg::*;

  localparam int NCOL = 64;
  localparam int NROW = 64;
  localparam int SDEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] p0, p1, p2, p3;
    logic [5:0] ccol, crow;
    logic [1:0] dir;
  } order_t;

  typedef struct packed {
    status_e    st;
    logic [5:0] wcol, wrow;
    logic [1:0] cval;
    logic [5:0] pcol, prow;
    logic       at_exit;
  } report_t;

  // One row of the directed table; chk set means exp is typed in by hand.
  typedef struct packed {
    order_t  ord;
    logic    chk;
    report_t exp;
  } row_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic start_i = 1'b0, busy_o;
  logic [1:0] command_i = '0, pick_0_i = '0, pick_1_i = '0, pick_2_i = '0, pick_3_i = '0;
  logic [5:0] cell_column_i = '0, cell_row_i = '0;
  logic [1:0] direction_i = '0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = '0;
  logic [5:0] cfg_data_i = '0;
  logic done_o, reached_exit_o;
  logic [1:0] status_o, cell_value_o;
  logic [5:0] walker_column_o, walker_row_o, player_column_o, player_row_o;

  dfs_maze_generator_core dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state.
  cell_e       maze [NROW][NCOL];
  logic [11:0] trail [SDEPTH];
  int          trail_len;
  int          wk_c, wk_r, pl_c, pl_r;
  int          span_c, span_r;
  report_t     pending_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          send_gap = 0;

  function automatic cell_e peek(int c, int r);
    if (c < 0 || r < 0 || c >= span_c || r >= span_r) return CELL_WALL;
    return maze[r][c];
  endfunction

  function automatic void poke(int c, int r, cell_e v);
    if (c >= 0 && r >= 0 && c < span_c && r < span_r) maze[r][c] = v;
  endfunction

  function automatic void lay_out();
    for (int r = 0; r < NROW; r++)
      for (int c = 0; c < NCOL; c++)
        maze[r][c] = (r < span_r && c < span_c && r[0] && c[0]) ? CELL_PATH : CELL_WALL;
    poke(1, 1, CELL_SEEN);
    if (span_c >= 2 && span_r >= 1) poke(span_c - 2, span_r - 1, CELL_PATH);
    trail_len = 0;
    wk_c = 1; wk_r = 1; pl_c = 1; pl_r = 1;
  endfunction

  function automatic status_e carve(order_t o);
    int dirs [4];
    int pk [4];
    int t, nx, ny, d;
    int dc [4] = '{0, 0, 1, -1};
    int dr [4] = '{1, -1, 0, 0};
    dirs = '{0, 1, 2, 3};
    pk = '{o.p0, o.p1, o.p2, o.p3};
    poke(wk_c, wk_r, CELL_SEEN);
    for (int i = 0; i < 4; i++) begin
      t = dirs[i]; dirs[i] = dirs[pk[i]]; dirs[pk[i]] = t;
    end
    if (trail_len < SDEPTH) begin
      for (int i = 0; i < 4; i++) begin
        d = dirs[i];
        nx = wk_c + 2 * dc[d];
        ny = wk_r + 2 * dr[d];
        if (nx > 0 && nx < span_c && ny > 0 && ny < span_r && peek(nx, ny) == CELL_PATH) begin
          poke(wk_c + dc[d], wk_r + dr[d], CELL_SEEN);
          trail[trail_len] = {wk_r[5:0], wk_c[5:0]};
          trail_len++;
          wk_c = nx; wk_r = ny;
          return ST_CARVED;
        end
      end
    end
    if (trail_len > 0) begin
      trail_len--;
      wk_c = trail[trail_len][5:0];
      wk_r = trail[trail_len][11:6];
      return ST_BACK;
    end
    return ST_FINISHED;
  endfunction

  function automatic report_t predict_maze(order_t o);
    report_t rp;
    int nc, nr;
    rp = '0;
    rp.st = ST_NONE;
    case (o.cmd)
      CMD_CLEAR: lay_out();
      CMD_STEP:  rp.st = carve(o);
      CMD_READ:  rp.cval = peek(o.ccol, o.crow);
      default: begin
        nc = pl_c; nr = pl_r;
        case (move_e'(o.dir))
          MV_UP:   nr--;
          MV_DOWN: nr++;
          MV_LEFT: nc--;
          default: nc++;
        endcase
        if (peek(nc, nr) != CELL_WALL) begin
          pl_c = nc; pl_r = nr;
        end
      end
    endcase
    rp.wcol = wk_c[5:0]; rp.wrow = wk_r[5:0];
    rp.pcol = pl_c[5:0]; rp.prow = pl_r[5:0];
    rp.at_exit = (span_c >= 2 && pl_c == span_c - 2 && pl_r == span_r - 1);
    return rp;
  endfunction

  // Result monitor and watchdog.
  always @(posedge clk_i) begin
    report_t got, want;
    if (rst_ni) begin
      idle_cycles <= (done_o || (start_i && !busy_o)) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_dfs_maze_generator_core failed");
        $finish;
      end
      if (done_o) begin
        got = '{status_e'(status_o), walker_column_o, walker_row_o, cell_value_o,
                player_column_o, player_row_o, reached_exit_o};
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
    end
  end

  // start_i stays high after a transfer so that the next item can follow at once;
  // it drops before an idle gap and in drain().
  task automatic send(order_t o, logic chk, report_t exp);
    report_t rp;
    if (send_gap > 0) start_i <= 1'b0;
    while (send_gap-- > 0) @(posedge clk_i);
    command_i <= o.cmd;
    pick_0_i <= o.p0; pick_1_i <= o.p1; pick_2_i <= o.p2; pick_3_i <= o.p3;
    cell_column_i <= o.ccol; cell_row_i <= o.crow; direction_i <= o.dir;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    rp = predict_maze(o);
    if (chk && rp !== exp) begin
      $display("%0t: table row expected %p predictor %p", $time, exp, rp);
      errors++;
    end
    pending_q.push_back(rp);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_size(int w, int h);
    drain();
    cfg_we_i <= 1'b1; cfg_index_i <= REG_WIDTH[0:0]; cfg_data_i <= w[5:0];
    @(posedge clk_i);
    cfg_index_i <= REG_HEIGHT[0:0]; cfg_data_i <= h[5:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    span_c = w; span_r = h;
  endtask

  function automatic order_t rand_order(int step_pct);
    order_t o;
    int k = $urandom_range(99);
    o = '{cmd_e'(2'($urandom)), 2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom),
          6'($urandom), 6'($urandom), 2'($urandom)};
    if (k < step_pct) o.cmd = CMD_STEP;
    else if (k < step_pct + 2) o.cmd = CMD_CLEAR;
    else if (k < step_pct + 15) o.cmd = CMD_READ;
    else if (k < 100) o.cmd = CMD_MOVE;
    if ($urandom_range(1) == 1) begin
      o.ccol = 6'($urandom_range(span_c)); o.crow = 6'($urandom_range(span_r));
    end
    return o;
  endfunction

  function automatic report_t rep(status_e s, int wc, int wr, int v, int pc, int pr, int e);
    return '{s, wc[5:0], wr[5:0], v[1:0], pc[5:0], pr[5:0], e[0]};
  endfunction

  function automatic order_t ord(cmd_e c, int p0, int p1, int p2, int p3,
                                 int cc, int cr, int d);
    return '{c, p0[1:0], p1[1:0], p2[1:0], p3[1:0], cc[5:0], cr[5:0], d[1:0]};
  endfunction

  row_t plan [$];

  initial begin
    int sizes_c [6] = '{5, 63, 7, 41, 9, 6};
    int sizes_r [6] = '{63, 5, 7, 25, 9, 6};
    int phase_items, send_pct;
    report_t none;
    span_c = RESET_WIDTH; span_r = RESET_HEIGHT;
    lay_out();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset-size grid: reads of a corner, the start, the exit, an inner cell and far outside.
    plan.push_back('{ord(CMD_READ, 0, 0, 0, 0, 0, 0, 0), 1,
                     rep(ST_NONE, 1, 1, CELL_WALL, 1, 1, 0)});
    plan.push_back('{ord(CMD_READ, 3, 3, 3, 3, 1, 1, 3), 1,
                     rep(ST_NONE, 1, 1, CELL_SEEN, 1, 1, 0)});
    plan.push_back('{ord(CMD_READ, 0, 0, 0, 0, 39, 24, 0), 1,
                     rep(ST_NONE, 1, 1, CELL_PATH, 1, 1, 0)});
    plan.push_back('{ord(CMD_READ, 0, 0, 0, 0, 63, 63, 0), 1,
                     rep(ST_NONE, 1, 1, CELL_WALL, 1, 1, 0)});
    plan.push_back('{ord(CMD_READ, 0, 0, 0, 0, 3, 3, 0), 1,
                     rep(ST_NONE, 1, 1, CELL_PATH, 1, 1, 0)});
    // Moves into walls do nothing.
    plan.push_back('{ord(CMD_MOVE, 0, 0, 0, 0, 0, 0, MV_UP), 1,
                     rep(ST_NONE, 1, 1, 0, 1, 1, 0)});
    plan.push_back('{ord(CMD_MOVE, 0, 0, 0, 0, 0, 0, MV_LEFT), 1,
                     rep(ST_NONE, 1, 1, 0, 1, 1, 0)});
    plan.push_back('{ord(CMD_STEP, 0, 1, 2, 3, 0, 0, 0), 0, none});
    plan.push_back('{ord(CMD_STEP, 3, 2, 1, 0, 0, 0, 0), 0, none});
    plan.push_back('{ord(CMD_STEP, 1, 0, 3, 2, 0, 0, 0), 0, none});
    plan.push_back('{ord(CMD_MOVE, 0, 0, 0, 0, 0, 0, MV_DOWN), 0, none});
    plan.push_back('{ord(CMD_MOVE, 0, 0, 0, 0, 0, 0, MV_RIGHT), 0, none});
    plan.push_back('{ord(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1,
                     rep(ST_NONE, 1, 1, 0, 1, 1, 0)});
    foreach (plan[i]) send(plan[i].ord, plan[i].chk, plan[i].exp);

    // Smallest grid: carve it to the end, move the player about and read the exit.
    set_size(5, 5);
    send(ord(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, rep(ST_NONE, 1, 1, 0, 1, 1, 0));
    for (int i = 0; i < 9; i++) send(ord(CMD_STEP, i, i + 1, i + 2, i + 3, 0, 0, 0), 0, none);
    send(ord(CMD_STEP, 0, 0, 0, 0, 0, 0, 0), 1, rep(ST_FINISHED, 1, 1, 0, 1, 1, 0));
    for (int i = 0; i < 8; i++) send(ord(CMD_MOVE, 0, 0, 0, 0, 0, 0, i % 4), 0, none);
    send(ord(CMD_READ, 0, 0, 0, 0, 3, 4, 0), 1, rep(ST_NONE, 1, 1, CELL_PATH, pl_c, pl_r,
                                                     (pl_c == 3 && pl_r == 4)));
    drain();

    // Random phases over several sizes, with three idling regimes.
    for (int ph = 0; ph < 6; ph++) begin
      set_size(sizes_c[ph], sizes_r[ph]);
      send(ord(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0, none);
      send_pct = (ph < 2) ? 12 : (ph < 4) ? 82 : 0;
      phase_items = (sizes_c[ph] * sizes_r[ph] > 300) ? 160 : 120;
      for (int i = 0; i < phase_items; i++) begin
        send_gap = ($urandom_range(99) < send_pct) ? $urandom_range(1, 4) : 0;
        if (i == phase_items / 2) drain();
        send(rand_order(55), 0, none);
      end
    end
    // Register changes without a clear can leave the walker outside the grid.
    set_size(5, 5);
    for (int i = 0; i < 30; i++) send(rand_order(50), 0, none);

    drain();
    if (errors == 0) begin
      $display("tb_dfs_maze_generator_core passed");
    end else begin
      $display("tb_dfs_maze_generator_core failed");
    end
    $finish;
  end

endmodule
